// File: hw/rtl/htb_pkg.sv
// shared types and constants of the huffman tree builder
package htb_pkg;

    localparam int SUM_BITS  = 30;
    localparam int NODE_BITS = 7;
    localparam int SYM_BITS  = 6;
    localparam int WIN_BITS  = 24;
    localparam int QDEPTH    = 2;

    localparam logic [1:0] ST_MERGE  = 2'd0;
    localparam logic [1:0] ST_SINGLE = 2'd1;
    localparam logic [1:0] ST_EMPTY  = 2'd2;

    typedef struct packed {
        logic [SUM_BITS-1:0]  w;
        logic [NODE_BITS-1:0] node;
    } t_entry;

    typedef struct packed {
        t_entry ent;
        logic   fin;
    } t_qitem;

endpackage

// File: hw/rtl/huffman_tree_builder.sv
// huffman tree builder top level
// an accepted nonzero weight is queued, then sorted into the list when popped
// throughput: one weight per cycle, set by the shift-insert list, unless stalled
// after the final item, one result per cycle unless the receiver stalls: n-1 merges
// for n nonzero weights; results appear the cycle after each build step, registered
// synchronous active-low reset empties the queue, the list and the output
module huffman_tree_builder import htb_pkg::*; #(
    parameter int SYMBOLS     = 32,
    parameter int WEIGHT_BITS = 24
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [SYM_BITS-1:0]  i_symbol,
    input  logic [WIN_BITS-1:0]  i_weight,
    input  logic                 i_final_item,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [1:0]           o_status,
    output logic [NODE_BITS-1:0] o_left_node,
    output logic [NODE_BITS-1:0] o_right_node,
    output logic [NODE_BITS-1:0] o_parent_node,
    output logic [SUM_BITS-1:0]  o_sum_weight,
    output logic                 o_final_result
);

    logic   q_valid, q_pop;
    t_qitem q_item;

    htb_front #(.WEIGHT_BITS(WEIGHT_BITS)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_symbol     (i_symbol),
        .i_weight     (i_weight),
        .i_final_item (i_final_item),
        .o_q_valid    (q_valid),
        .o_q_item     (q_item),
        .i_q_pop      (q_pop)
    );

    htb_back #(.SYMBOLS(SYMBOLS)) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_valid      (q_valid),
        .i_q_item       (q_item),
        .o_q_pop        (q_pop),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_status       (o_status),
        .o_left_node    (o_left_node),
        .o_right_node   (o_right_node),
        .o_parent_node  (o_parent_node),
        .o_sum_weight   (o_sum_weight),
        .o_final_result (o_final_result)
    );

endmodule

// File: hw/rtl/htb_front.sv
// input acceptance, zero weight filtering and the item queue
module htb_front import htb_pkg::*; #(
    parameter int WEIGHT_BITS = 24
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [SYM_BITS-1:0] i_symbol,
    input  logic [WIN_BITS-1:0] i_weight,
    input  logic                i_final_item,
    output logic                o_q_valid,
    output t_qitem              o_q_item,
    input  logic                i_q_pop
);

    localparam int WB = (WEIGHT_BITS < WIN_BITS) ? WEIGHT_BITS : WIN_BITS;
    localparam logic [SUM_BITS-1:0] WMASK = SUM_BITS'((64'd1 << WB) - 64'd1);

    t_qitem            r_q [QDEPTH];
    logic [1:0]        r_cnt, n_cnt;
    logic              r_rd, n_rd;
    logic              r_wr, n_wr;
    t_qitem            item;
    logic              accept, push;

    assign o_stall   = (r_cnt == 2'(QDEPTH));
    assign accept    = i_valid && !o_stall;
    assign item.ent.w    = SUM_BITS'(i_weight) & WMASK;
    assign item.ent.node = {1'b0, i_symbol};
    assign item.fin      = i_final_item;
    assign push      = accept && ((item.ent.w != '0) || i_final_item);
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_item  = r_q[r_rd];

    always_comb begin
        n_cnt = r_cnt + 2'(push) - 2'(i_q_pop);
        n_rd  = i_q_pop ? ~r_rd : r_rd;
        n_wr  = push ? ~r_wr : r_wr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_rd  <= 1'b0;
            r_wr  <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            r_rd  <= n_rd;
            r_wr  <= n_wr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr] <= item;
        end
    end

endmodule

// File: hw/rtl/htb_back.sv
// sorted shift-insert list and merge sequencer
module htb_back import htb_pkg::*; #(
    parameter int SYMBOLS = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_q_valid,
    input  t_qitem               i_q_item,
    output logic                 o_q_pop,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [1:0]           o_status,
    output logic [NODE_BITS-1:0] o_left_node,
    output logic [NODE_BITS-1:0] o_right_node,
    output logic [NODE_BITS-1:0] o_parent_node,
    output logic [SUM_BITS-1:0]  o_sum_weight,
    output logic                 o_final_result
);

    localparam int CW = $clog2(SYMBOLS + 1);

    typedef enum logic [1:0] {
        S_FILL  = 2'b01,
        S_BUILD = 2'b10
    } t_state;

    t_state              r_state, n_state;
    t_entry              r_ent [SYMBOLS];
    t_entry              n_ent [SYMBOLS];
    t_entry              src   [SYMBOLS];
    logic [SYMBOLS-1:0]  gt;
    logic [CW-1:0]       r_count, n_count, vcount;
    logic [5:0]          r_merge, n_merge;
    t_entry              key;
    logic                ins_en, step, out_free;
    logic [SUM_BITS:0]   sum_full;
    logic [SUM_BITS-1:0] sum;
    logic [NODE_BITS-1:0] parent;

    logic                 r_ovalid;
    logic [1:0]           r_status;
    logic [NODE_BITS-1:0] r_left, r_right, r_parent;
    logic [SUM_BITS-1:0]  r_sum;
    logic                 r_fin;

    assign out_free = !r_ovalid || !i_stall;
    assign o_q_pop  = (r_state == S_FILL) && i_q_valid;
    assign step     = (r_state == S_BUILD) && out_free;
    assign sum_full = {1'b0, r_ent[0].w} + {1'b0, r_ent[1].w};
    assign sum      = sum_full[SUM_BITS] ? '1 : sum_full[SUM_BITS-1:0];
    assign parent   = NODE_BITS'(SYMBOLS) + NODE_BITS'(r_merge);

    always_comb begin
        if (r_state == S_BUILD) begin
            vcount = r_count - CW'(2);
            key.w    = sum;
            key.node = parent;
            ins_en   = step && (r_count >= CW'(2));
        end else begin
            vcount = r_count;
            key    = i_q_item.ent;
            ins_en = o_q_pop && (i_q_item.ent.w != '0) && (r_count < CW'(SYMBOLS));
        end
        for (int i = 0; i < SYMBOLS; i++) begin
            if (r_state == S_BUILD && i + 2 < SYMBOLS) begin
                src[i] = r_ent[i + 2];
            end else begin
                src[i] = r_ent[i];
            end
            gt[i] = (CW'(i) < vcount) && (src[i].w > key.w);
        end
        for (int i = 0; i < SYMBOLS; i++) begin
            if (i > 0 && gt[i - 1]) begin
                n_ent[i] = src[i - 1];
            end else if (gt[i] || CW'(i) == vcount) begin
                n_ent[i] = key;
            end else begin
                n_ent[i] = src[i];
            end
        end
    end

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_merge = r_merge;
        case (r_state)
            S_FILL: begin
                if (ins_en) begin
                    n_count = r_count + CW'(1);
                end
                if (o_q_pop && i_q_item.fin) begin
                    n_state = S_BUILD;
                end
            end
            S_BUILD: begin
                if (step) begin
                    if (r_count <= CW'(2)) begin
                        n_state = S_FILL;
                        n_count = '0;
                        n_merge = '0;
                    end else begin
                        n_count = r_count - CW'(1);
                        n_merge = r_merge + 6'd1;
                    end
                end
            end
            default: begin
                n_state = S_FILL;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_FILL;
            r_count  <= '0;
            r_merge  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_merge <= n_merge;
            if (step) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ins_en) begin
            for (int i = 0; i < SYMBOLS; i++) begin
                r_ent[i] <= n_ent[i];
            end
        end
        if (step) begin
            r_fin <= (r_count <= CW'(2));
            if (r_count == '0) begin
                r_status <= ST_EMPTY;
                r_left   <= '0;
                r_right  <= '0;
                r_parent <= '0;
                r_sum    <= '0;
            end else if (r_count == CW'(1)) begin
                r_status <= ST_SINGLE;
                r_left   <= r_ent[0].node;
                r_right  <= '0;
                r_parent <= '0;
                r_sum    <= r_ent[0].w;
            end else begin
                r_status <= ST_MERGE;
                r_left   <= r_ent[0].node;
                r_right  <= r_ent[1].node;
                r_parent <= parent;
                r_sum    <= sum;
            end
        end
    end

    assign o_valid        = r_ovalid;
    assign o_status       = r_status;
    assign o_left_node    = r_left;
    assign o_right_node   = r_right;
    assign o_parent_node  = r_parent;
    assign o_sum_weight   = r_sum;
    assign o_final_result = r_fin;

`ifndef ASSERT_OFF
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(SYMBOLS)) else $error("entry count above capacity");
    a_fill_merge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_FILL |-> r_merge == '0) else $error("merge count not clear");
    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step && r_count <= CW'(2) |=> r_state == S_FILL && r_count == '0 && o_final_result)
        else $error("build did not end");
    a_no_pop_build: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_BUILD |-> !o_q_pop) else $error("queue popped during build");
`endif

endmodule

// File: test/huffman_tree_builder_tb.sv
// testbench for the huffman tree builder: predicted merge records against the block
`timescale 1ns / 100ps

module huffman_tree_builder_tb;
    import htb_pkg::*;

    localparam int NSYM = 32;
    localparam logic [SUM_BITS-1:0] SUM_SAT = {SUM_BITS{1'b1}};

    typedef struct packed {
        logic [1:0]           status;
        logic [NODE_BITS-1:0] left_node;
        logic [NODE_BITS-1:0] right_node;
        logic [NODE_BITS-1:0] parent_node;
        logic [SUM_BITS-1:0]  sum_weight;
        logic                 final_result;
    } t_merge;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_stall;
    logic [SYM_BITS-1:0] i_symbol = '0;
    logic [WIN_BITS-1:0] i_weight = '0;
    logic i_final_item = 1'b0;
    logic o_valid;
    logic i_stall = 1'b0;
    logic [1:0] o_status;
    logic [NODE_BITS-1:0] o_left_node, o_right_node, o_parent_node;
    logic [SUM_BITS-1:0] o_sum_weight;
    logic o_final_result;

    huffman_tree_builder #(.SYMBOLS(NSYM), .WEIGHT_BITS(24)) uut (.*);

    always #5 i_clk = ~i_clk;

    logic [SUM_BITS-1:0]  list_w[NSYM];
    logic [NODE_BITS-1:0] list_n[NSYM];
    int list_count = 0;
    t_merge expected_merges[$];
    int errors = 0;
    int hold_cycles = 0;
    int gap_left = 0;
    int burst_left = 0;

    task automatic sort_in(input logic [SUM_BITS-1:0] w, input logic [NODE_BITS-1:0] nd);
        int pos;
        pos = list_count;
        if (pos >= NSYM) return;
        while (pos > 0 && list_w[pos-1] > w) begin
            list_w[pos] = list_w[pos-1];
            list_n[pos] = list_n[pos-1];
            pos--;
        end
        list_w[pos] = w;
        list_n[pos] = nd;
        list_count++;
    endtask

    task automatic predict_tree(input logic [SYM_BITS-1:0] sym, input logic [WIN_BITS-1:0] w,
                                input logic fin);
        t_merge m;
        logic [SUM_BITS:0] s;
        int merges;
        if (w != 0) sort_in(SUM_BITS'(w), NODE_BITS'(sym));
        if (!fin) return;
        merges = 0;
        m = '0;
        m.final_result = 1'b1;
        if (list_count == 0) begin
            m.status = ST_EMPTY;
            expected_merges.push_back(m);
        end else if (list_count == 1) begin
            m.status = ST_SINGLE;
            m.left_node = list_n[0];
            m.sum_weight = list_w[0];
            expected_merges.push_back(m);
        end else begin
            while (list_count >= 2) begin
                s = list_w[0] + list_w[1];
                m.status = ST_MERGE;
                m.left_node = list_n[0];
                m.right_node = list_n[1];
                m.parent_node = NODE_BITS'(NSYM + merges);
                m.sum_weight = s[SUM_BITS] ? SUM_SAT : s[SUM_BITS-1:0];
                for (int i = 2; i < list_count; i++) begin
                    list_w[i-2] = list_w[i];
                    list_n[i-2] = list_n[i];
                end
                list_count -= 2;
                merges = (merges + 1) & 63;
                sort_in(m.sum_weight, m.parent_node);
                m.final_result = (list_count == 1);
                expected_merges.push_back(m);
            end
        end
        list_count = 0;
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got, input logic [31:0] exp);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, exp, $realtime);
        errors++;
    endtask

    // sender paces itself in bursts with gaps
    task automatic send_weight(input logic [SYM_BITS-1:0] sym, input logic [WIN_BITS-1:0] w,
                               input logic fin);
        while (gap_left > 0) begin
            @(posedge i_clk);
            i_valid <= 1'b0;
            gap_left--;
        end
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
        end
        burst_left--;
        @(posedge i_clk);
        i_valid <= 1'b1;
        i_symbol <= sym;
        i_weight <= w;
        i_final_item <= fin;
        do @(posedge i_clk); while (o_stall);
        predict_tree(sym, w, fin);
        i_valid <= 1'b0;
        while (gap_left > 0 && burst_left == 0) begin
            @(posedge i_clk);
            gap_left--;
        end
    endtask

    task automatic wait_drained();
        while (expected_merges.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic logic [WIN_BITS-1:0] rand_weight();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return {WIN_BITS{1'b1}} - WIN_BITS'($urandom_range(0, 3));
            2: return WIN_BITS'($urandom_range(1, 4));
            default: return WIN_BITS'($urandom);
        endcase
    endfunction

    task automatic test_special_sets();
        send_weight(6'd5, 24'd0, 1'b1);
        send_weight(6'd63, 24'hFFFFFF, 1'b1);
        send_weight(6'd1, 24'd0, 1'b0);
        send_weight(6'd2, 24'd7, 1'b0);
        send_weight(6'd3, 24'd0, 1'b1);
        send_weight(6'd0, 24'd3, 1'b0);
        send_weight(6'd9, 24'd3, 1'b0);
        send_weight(6'd9, 24'd3, 1'b0);
        send_weight(6'd42, 24'd1, 1'b1);
        send_weight(6'd0, 24'hFFFFFF, 1'b0);
        send_weight(6'd21, 24'hFFFFFF, 1'b0);
        send_weight(6'd42, 24'hFFFFFF, 1'b0);
        send_weight(6'd63, 24'hFFFFFF, 1'b1);
        send_weight(6'd10, 24'h555555, 1'b0);
        send_weight(6'd53, 24'hAAAAAA, 1'b1);
        wait_drained();
    endtask

    task automatic test_full_list();
        for (int i = 0; i < NSYM + 2; i++)
            send_weight(SYM_BITS'(i), WIN_BITS'($urandom_range(1, 50)), i == NSYM + 1);
        wait_drained();
    endtask

    task automatic test_random_sets();
        int n, sent;
        sent = 0;
        while (sent < 130) begin
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 10);
            for (int i = 0; i <= n; i++)
                send_weight(SYM_BITS'($urandom), rand_weight(), i == n);
            sent += n + 1;
        end
        wait_drained();
    endtask

    task automatic test_backpressure();
        hold_cycles = 80;
        for (int i = 0; i < 20; i++)
            send_weight(SYM_BITS'($urandom), WIN_BITS'($urandom_range(1, 1000)), i == 19);
        send_weight(6'd7, 24'd9, 1'b0);
        send_weight(6'd8, 24'd9, 1'b1);
        wait_drained();
    endtask

    // receiver stall pattern, with a long hold-off when requested
    always @(posedge i_clk) begin
        if (hold_cycles > 0) begin
            i_stall <= 1'b1;
            hold_cycles <= hold_cycles - 1;
        end else begin
            i_stall <= ($urandom_range(0, 3) == 0) && (($time % 64'd2000) > 64'd700);
        end
    end

    always @(posedge i_clk) begin
        t_merge exp_m;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_merges.size() == 0) begin
                report_mismatch("unexpected transfer", o_status, 0);
            end else begin
                exp_m = expected_merges.pop_front();
                if (o_status !== exp_m.status) report_mismatch("status", o_status, exp_m.status);
                if (o_left_node !== exp_m.left_node)
                    report_mismatch("left_node", o_left_node, exp_m.left_node);
                if (o_right_node !== exp_m.right_node)
                    report_mismatch("right_node", o_right_node, exp_m.right_node);
                if (o_parent_node !== exp_m.parent_node)
                    report_mismatch("parent_node", o_parent_node, exp_m.parent_node);
                if (o_sum_weight !== exp_m.sum_weight)
                    report_mismatch("sum_weight", o_sum_weight, exp_m.sum_weight);
                if (o_final_result !== exp_m.final_result)
                    report_mismatch("final_result", o_final_result, exp_m.final_result);
            end
        end
    end

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_special_sets();
        test_full_list();
        test_backpressure();
        test_random_sets();
        repeat (20) @(posedge i_clk);
        if (errors == 0 && expected_merges.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// File: files.f
hw/rtl/htb_pkg.sv
hw/rtl/htb_front.sv
hw/rtl/htb_back.sv
hw/rtl/huffman_tree_builder.sv
test/huffman_tree_builder_tb.sv
